@@ hdl/gpstt_pkg.sv @@
// Shared types, character codes and decode function for the GPS time and tracking parser.
package gpstt_pkg;

	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_E       = 8'h45;
	localparam logic [7:0] CH_Q       = 8'h71;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] LOCK_RESET = 8'd16;

	localparam int TIME_LEN = 12;
	localparam int IDX_W    = $clog2(TIME_LEN);

	localparam logic [5:0] TIME_END = 6'd12;
	localparam logic [5:0] VIS_POS  = 6'd36;
	localparam logic [5:0] TRK_POS  = 6'd37;

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_TYPE,
		PH_EQ,
		PH_HB,
		PH_TIME,
		PH_TRACK
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic       tracking_lock;
		logic [7:0] visible_sats;
		logic [7:0] tracked_sats;
	} gpstt_result_t;

	// Two ASCII characters to (hi-48)*10+(lo-48), kept to eight bits.
	function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0]  dh;
		logic [7:0]  dl;
		logic [10:0] prod;
		dh   = hi - ASCII_ZERO;
		dl   = lo - ASCII_ZERO;
		prod = 11'({dh, 3'b000}) + 11'({dh, 1'b0});
		return prod[7:0] + dl;
	endfunction

endpackage

@@ hdl/gpstt_parser.sv @@
// Message parser state machine, time character store, lock counter and report decode.
module gpstt_parser
	import gpstt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    lock_threshold,
	output logic          res_fire,
	output gpstt_result_t result
);

	parse_phase_t phase_q, phase_d;
	logic [5:0]   count_q, count_d;
	logic [7:0]   visible_q, visible_d;
	logic [7:0]   tracked_q, tracked_d;
	logic [7:0]   good_q, good_d;
	logic         lock_q, lock_d;
	logic [7:0]   chars_q [TIME_LEN];
	logic         char_we;
	logic [5:0]   track_cnt;
	logic [7:0]   good_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR1;
			count_q   <= '0;
			visible_q <= '0;
			tracked_q <= '0;
			good_q    <= '0;
			lock_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			visible_q <= visible_d;
			tracked_q <= tracked_d;
			good_q    <= good_d;
			lock_q    <= lock_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && char_we) begin
			chars_q[count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	assign track_cnt = count_q + 6'd1;
	assign good_inc  = good_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		visible_d = visible_q;
		tracked_d = tracked_q;
		good_d    = good_q;
		lock_d    = lock_q;
		char_we   = 1'b0;
		res_fire  = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				if (rx_byte == CH_AT) phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				if (rx_byte == CH_AT) begin
					phase_d = PH_TYPE;
					count_d = '0;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_TYPE: begin
				priority if (rx_byte == CH_E) phase_d = PH_EQ;
				else if (rx_byte == CH_H) phase_d = PH_HB;
				else phase_d = PH_HDR1;
			end
			PH_EQ: begin
				phase_d = (rx_byte == CH_Q) ? PH_TIME : PH_HDR1;
			end
			PH_HB: begin
				phase_d = (rx_byte == CH_B) ? PH_TRACK : PH_HDR1;
			end
			PH_TIME: begin
				if (count_q < TIME_END) begin
					if (rx_byte != CH_COMMA) begin
						char_we = 1'b1;
						count_d = count_q + 6'd1;
					end
				end else begin
					phase_d  = PH_HDR1;
					res_fire = 1'b1;
					if (visible_q != '0 && tracked_q != '0) begin
						good_d = good_inc;
						if (good_inc == lock_threshold) lock_d = 1'b1;
					end else begin
						good_d = '0;
						lock_d = 1'b0;
					end
				end
			end
			PH_TRACK: begin
				count_d = track_cnt;
				if (track_cnt == VIS_POS) visible_d = rx_byte;
				if (track_cnt == TRK_POS) begin
					tracked_d = rx_byte;
					phase_d   = PH_HDR1;
				end
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
	end

	always_comb begin
		result.year          = pair_value(chars_q[4], chars_q[5]);
		result.month         = pair_value(chars_q[0], chars_q[1]);
		result.day           = pair_value(chars_q[2], chars_q[3]);
		result.hour          = pair_value(chars_q[6], chars_q[7]);
		result.minute        = pair_value(chars_q[8], chars_q[9]);
		result.second        = pair_value(chars_q[10], chars_q[11]);
		result.tracking_lock = lock_d;
		result.visible_sats  = visible_q;
		result.tracked_sats  = tracked_q;
	end

	a_time_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TIME |-> count_q <= TIME_END)
		else $error("time character count ran past twelve");

	a_report_ends_msg: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_fire |=> phase_q == PH_HDR1 && count_q == TIME_END)
		else $error("parser did not return to hunting after a time report");

	a_lock_only_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lock_q) |-> $past(step && res_fire))
		else $error("tracking lock set outside a time report");

	a_track_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TRACK |-> count_q < TRK_POS)
		else $error("tracking byte count ran past the tracked position");

endmodule

@@ hdl/gps_time_track_message_parser_core.sv @@
// Top level of the GPS time and tracking message parser with input and result registers.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     rx_byte
//   result    out_valid / out_stall   year month day hour minute second tracking_lock
//                                     visible_sats tracked_sats
//   config    cfg_wr_en               cfg_wr_data (lock threshold)
//
// One byte is taken each cycle while in_stall is low; the byte that ends a time report goes to the
// byte register, which feeds the parser; the parser state and result register update when it steps.
// Reset clears the parser state and the lock counter and sets the threshold to 16, at once.
// A stalled result holds only a byte that ends another time report; other bytes still flow.
module gps_time_track_message_parser_core
	import gpstt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] year,
	output logic [7:0] month,
	output logic [7:0] day,
	output logic [7:0] hour,
	output logic [7:0] minute,
	output logic [7:0] second,
	output logic       tracking_lock,
	output logic [7:0] visible_sats,
	output logic [7:0] tracked_sats,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic          valid_s1;
	logic [7:0]    rx_byte_s1;
	logic          out_valid_q;
	gpstt_result_t result_q;
	gpstt_result_t result;
	logic [7:0]    threshold_q;
	logic          res_fire;
	logic          out_free;
	logic          step;
	logic          in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!res_fire || out_free);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= LOCK_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	gpstt_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx_byte        (rx_byte_s1),
		.lock_threshold (threshold_q),
		.res_fire       (res_fire),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_fire) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign year          = result_q.year;
	assign month         = result_q.month;
	assign day           = result_q.day;
	assign hour          = result_q.hour;
	assign minute        = result_q.minute;
	assign second        = result_q.second;
	assign tracking_lock = result_q.tracking_lock;
	assign visible_sats  = result_q.visible_sats;
	assign tracked_sats  = result_q.tracked_sats;

	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && res_fire))
		else $error("result beat raised without a report-ending byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(step && res_fire))
		else $error("pending result overwritten");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(rx_byte_s1))
		else $error("held byte lost before the parser took it");

endmodule
